@@ design/bracket_balance_checker_unit_defines.svh @@
// Assertion macros shared by the bracket balance checker RTL.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bbc_pkg.sv @@
// Package for the bracket balance checker: beat types, status codes,
// character constants and bracket decode functions. No dependencies.
`timescale 1ns / 1ps

package bbc_pkg;

  // Default stack depth and width of one stored opener code
  localparam int STACK_DEPTH_DEF = 64;
  localparam int OPENER_W        = 2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ODD      = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNCLOSED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Opener codes; OP_NONE marks a non-opener or a wildcard closer
  localparam logic [OPENER_W-1:0] OP_PAREN   = 2'd0;
  localparam logic [OPENER_W-1:0] OP_SQUARE  = 2'd1;
  localparam logic [OPENER_W-1:0] OP_CURLY   = 2'd2;
  localparam logic [OPENER_W-1:0] OP_NONE    = 2'd3;

  // Bracket characters
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

  // Input beat
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } sym_t;

  // Output beat
  typedef struct packed {
    logic       valid_res;
    logic [2:0] status;
  } res_t;

  // Verdict from the stack core to the output stage
  typedef struct packed {
    logic done;
    res_t res;
  } verdict_t;

  // Opener code of a character, OP_NONE if it does not open
  function automatic logic [OPENER_W-1:0] opener_code(input logic [7:0] c);
    logic [OPENER_W-1:0] code;
    code = OP_NONE;
    if (c == CH_LPAREN)  code = OP_PAREN;
    if (c == CH_LSQUARE) code = OP_SQUARE;
    if (c == CH_LCURLY)  code = OP_CURLY;
    return code;
  endfunction

  // Opener a closer requires, OP_NONE for a wildcard
  function automatic logic [OPENER_W-1:0] closer_need(input logic [7:0] c);
    logic [OPENER_W-1:0] code;
    code = OP_NONE;
    if (c == CH_RPAREN)  code = OP_PAREN;
    if (c == CH_RSQUARE) code = OP_SQUARE;
    if (c == CH_RCURLY)  code = OP_CURLY;
    return code;
  endfunction

endpackage

@@ design/bbc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Uses bbc_pkg for its parameter defaults.
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = bbc_pkg::OPENER_W,
  parameter int DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/bbc_core.sv @@
// Stack core of the bracket balance checker: opener stack in RAM, depth,
// parity and first-error registers, verdict. Uses bbc_pkg and bbc_ram.
`timescale 1ns / 1ps
`include "bracket_balance_checker_unit_defines.svh"

module bbc_core #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  bbc_pkg::sym_t     sym,
  output bbc_pkg::verdict_t verdict
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int OW = bbc_pkg::OPENER_W;

  // State registers
  logic [DW-1:0] depth, depth_next;
  logic          parity, parity_next;
  logic [2:0]    err, err_next;
  logic          fwd, fwd_next;
  logic [OW-1:0] fwd_val;

  // RAM port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [OW-1:0] wdata, rdata;

  // Decode
  logic [OW-1:0] code, need, top;
  logic          is_open;
  logic [2:0]    status;

  assign code    = bbc_pkg::opener_code(sym.symbol);
  assign need    = bbc_pkg::closer_need(sym.symbol);
  assign is_open = (code != bbc_pkg::OP_NONE);

  // Take the top from the forward register when last cycle pushed it
  assign top = fwd ? fwd_val : rdata;

  bbc_ram #(
    .WIDTH (OW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Push, pop or latch an error for one accepted beat
  always_comb begin
    depth_next  = depth;
    parity_next = parity;
    err_next    = err;
    fwd_next    = 1'b0;
    we          = 1'b0;
    waddr       = depth[AW-1:0];
    wdata       = code;
    if (acc) begin
      parity_next = ~parity;
      if (err == bbc_pkg::ST_OK) begin
        if (is_open) begin
          if (depth == DW'(STACK_DEPTH)) begin
            err_next = bbc_pkg::ST_OVERFLOW;
          end else begin
            we         = 1'b1;
            fwd_next   = 1'b1;
            depth_next = depth + DW'(1);
          end
        end else if (depth == '0) begin
          err_next = bbc_pkg::ST_EMPTY;
        end else if (need != bbc_pkg::OP_NONE && need != top) begin
          err_next = bbc_pkg::ST_MISMATCH;
        end else begin
          depth_next = depth - DW'(1);
        end
      end
    end
  end

  // Verdict on the last beat, odd length first
  always_comb begin
    priority if (parity_next) begin
      status = bbc_pkg::ST_ODD;
    end else if (err_next != bbc_pkg::ST_OK) begin
      status = err_next;
    end else if (depth_next != '0) begin
      status = bbc_pkg::ST_UNCLOSED;
    end else begin
      status = bbc_pkg::ST_OK;
    end
  end

  assign verdict.done          = acc && sym.last;
  assign verdict.res.status    = status;
  assign verdict.res.valid_res = (status == bbc_pkg::ST_OK);

  // Prefetch the next top of stack
  assign raddr = AW'(depth_next - DW'(1));

  // Advance state, clear it at the end of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      parity <= 1'b0;
      err    <= bbc_pkg::ST_OK;
      fwd    <= 1'b0;
    end else if (acc && sym.last) begin
      depth  <= '0;
      parity <= 1'b0;
      err    <= bbc_pkg::ST_OK;
      fwd    <= 1'b0;
    end else begin
      depth  <= depth_next;
      parity <= parity_next;
      err    <= err_next;
      fwd    <= fwd_next;
    end
  end

  // Forwarded top value
  always_ff @(posedge clk) begin
    fwd_val <= code;
  end

  `BBC_ASSERT_NOW(a_depth_bound, 1'b1, depth <= DW'(STACK_DEPTH), "stack depth above capacity")
  `BBC_ASSERT_NEXT(a_end_clears, acc && sym.last, depth == '0 && !parity && err == bbc_pkg::ST_OK, "state not cleared after last beat")
  `BBC_ASSERT_NEXT(a_err_freezes, acc && !sym.last && err != bbc_pkg::ST_OK, $stable(depth) && err == $past(err), "stack moved after an error")

endmodule

@@ design/bracket_balance_checker_unit.sv @@
// Bracket balance checker: one character per cycle unless sym_stall holds
// a last beat, verdict per string. The verdict is registered and appears on
// res in the cycle after the last beat is accepted. The top of stack is
// forwarded past the registered RAM read, so pushes and pops may follow
// each other directly. Reset (rst, synchronous): empty stack, even parity,
// no error; the stack RAM itself is not cleared.
`timescale 1ns / 1ps
`include "bracket_balance_checker_unit_defines.svh"

module bracket_balance_checker_unit #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          sym_valid,
  output logic          sym_stall,
  input  bbc_pkg::sym_t sym_data,
  output logic          res_valid,
  input  logic          res_stall,
  output bbc_pkg::res_t res_data
);

  logic              acc;
  bbc_pkg::verdict_t verdict;

  // Hold only a last beat while an earlier verdict waits
  assign sym_stall = res_valid && res_stall && sym_data.last;
  assign acc       = sym_valid && !sym_stall;

  bbc_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .sym     (sym_data),
    .verdict (verdict)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (verdict.done) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (verdict.done) begin
      res_data <= verdict.res;
    end
  end

  `BBC_ASSERT_NEXT(a_last_gives_res, acc && sym_data.last, res_valid, "no verdict after last beat")
  `BBC_ASSERT_NOW(a_res_consistent, res_valid, res_data.valid_res == (res_data.status == bbc_pkg::ST_OK), "verdict flag disagrees with status")
  `BBC_ASSERT_NEXT(a_no_spurious, !res_valid && !(acc && sym_data.last), !res_valid, "verdict without a last beat")

endmodule

@@ dv/bracket_balance_checker_unit_tb.sv @@
// Self-checking testbench for bracket_balance_checker_unit: bracket strings go in
// through the valid/stall symbol channel, and each verdict is checked against a
// bracket-stack predictor kept here. Depends on bbc_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module bracket_balance_checker_unit_tb;

  localparam int          NEST_MAX       = bbc_pkg::STACK_DEPTH_DEF;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam int unsigned PHASE_ITEMS    = 160;

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

  // One planned symbol beat with its idling mode and pressure marks
  typedef struct {
    bbc_pkg::sym_t beat;
    idle_mode_t    mode;
    bit            drain;
    bit            rx_hold;
  } sym_plan_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          sym_valid = 1'b0;
  logic          sym_stall;
  bbc_pkg::sym_t sym_data  = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  bbc_pkg::res_t res_data;

  sym_plan_t     symbols_pending[$];
  bbc_pkg::res_t verdicts_due[$];
  logic [7:0]    str_q[$];
  idle_mode_t    plan_mode   = IDLE_RX_HEAVY;
  idle_mode_t    cur_mode    = IDLE_RX_HEAVY;
  bit            mark_drain  = 1'b0;
  bit            mark_hold   = 1'b0;
  logic          hold_pulse  = 1'b0;
  int unsigned   hold_left   = 0;
  int unsigned   planned     = 0;
  int unsigned   mismatches  = 0;
  int unsigned   cycles      = 0;

  // Predictor state: opener stack, depth, length parity, first fault
  logic [1:0]  nest_stack[NEST_MAX];
  int unsigned nest_depth  = 0;
  bit          odd_len     = 1'b0;
  logic [2:0]  first_fault = bbc_pkg::ST_OK;

  bracket_balance_checker_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] opener_of(input logic [7:0] c);
    case (c)
      bbc_pkg::CH_LPAREN:  return bbc_pkg::OP_PAREN;
      bbc_pkg::CH_LSQUARE: return bbc_pkg::OP_SQUARE;
      bbc_pkg::CH_LCURLY:  return bbc_pkg::OP_CURLY;
      default:             return bbc_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic [1:0] closer_of(input logic [7:0] c);
    case (c)
      bbc_pkg::CH_RPAREN:  return bbc_pkg::OP_PAREN;
      bbc_pkg::CH_RSQUARE: return bbc_pkg::OP_SQUARE;
      bbc_pkg::CH_RCURLY:  return bbc_pkg::OP_CURLY;
      default:             return bbc_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] open_char(input logic [1:0] code);
    case (code)
      bbc_pkg::OP_PAREN:  return bbc_pkg::CH_LPAREN;
      bbc_pkg::OP_SQUARE: return bbc_pkg::CH_LSQUARE;
      default:            return bbc_pkg::CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input logic [1:0] code);
    case (code)
      bbc_pkg::OP_PAREN:  return bbc_pkg::CH_RPAREN;
      bbc_pkg::OP_SQUARE: return bbc_pkg::CH_RSQUARE;
      default:            return bbc_pkg::CH_RCURLY;
    endcase
  endfunction

  function automatic int unsigned tx_idle_pct(input idle_mode_t m);
    case (m)
      IDLE_RX_HEAVY: return 32;
      IDLE_TX_HEAVY: return 87;
      default:       return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct(input idle_mode_t m);
    case (m)
      IDLE_RX_HEAVY: return 87;
      IDLE_TX_HEAVY: return 32;
      default:       return 0;
    endcase
  endfunction

  // Any byte that is neither an opener nor a bracket closer
  function automatic logic [7:0] wild_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (opener_of(c) != bbc_pkg::OP_NONE || closer_of(c) != bbc_pkg::OP_NONE);
    return c;
  endfunction

  // Update the bracket stack for one accepted beat; queue a verdict on last
  task automatic track_symbol(input bbc_pkg::sym_t b);
    logic [1:0]    code;
    logic [1:0]    need;
    logic [2:0]    st;
    bbc_pkg::res_t r;
    odd_len = ~odd_len;
    if (first_fault == bbc_pkg::ST_OK) begin
      code = opener_of(b.symbol);
      if (code != bbc_pkg::OP_NONE) begin
        if (nest_depth >= NEST_MAX) begin
          first_fault = bbc_pkg::ST_OVERFLOW;
        end else begin
          nest_stack[nest_depth] = code;
          nest_depth++;
        end
      end else if (nest_depth == 0) begin
        first_fault = bbc_pkg::ST_EMPTY;
      end else begin
        need = closer_of(b.symbol);
        if (need != bbc_pkg::OP_NONE && need != nest_stack[nest_depth-1]) begin
          first_fault = bbc_pkg::ST_MISMATCH;
        end else begin
          nest_depth--;
        end
      end
    end
    if (b.last) begin
      if (odd_len) st = bbc_pkg::ST_ODD;
      else if (first_fault != bbc_pkg::ST_OK) st = first_fault;
      else if (nest_depth != 0) st = bbc_pkg::ST_UNCLOSED;
      else st = bbc_pkg::ST_OK;
      r.valid_res = (st == bbc_pkg::ST_OK);
      r.status    = st;
      verdicts_due.push_back(r);
      nest_depth  = 0;
      odd_len     = 1'b0;
      first_fault = bbc_pkg::ST_OK;
    end
  endtask

  task automatic add_beat(input logic [7:0] c, input bit is_last);
    sym_plan_t p;
    p.beat.symbol = c;
    p.beat.last   = is_last;
    p.mode        = plan_mode;
    p.drain       = mark_drain;
    p.rx_hold     = mark_hold;
    mark_drain    = 1'b0;
    mark_hold     = 1'b0;
    symbols_pending.push_back(p);
    planned++;
  endtask

  task automatic emit_string();
    foreach (str_q[i]) add_beat(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic add_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    emit_string();
  endtask

  // Random well-nested string; some closers are wildcards
  task automatic build_nest(input int unsigned pairs);
    logic [1:0]  opened[$];
    logic [1:0]  code;
    int unsigned opens_left;
    opens_left = pairs;
    str_q.delete();
    while (opens_left > 0 || opened.size() > 0) begin
      if (opens_left > 0 && (opened.size() == 0 || $urandom_range(1) == 1)) begin
        code = 2'($urandom_range(2));
        str_q.push_back(open_char(code));
        opened.push_back(code);
        opens_left--;
      end else begin
        code = opened.pop_back();
        if ($urandom_range(4) == 0) str_q.push_back(wild_char());
        else str_q.push_back(close_char(code));
      end
    end
  endtask

  // Straight run of openers, then closers back down
  task automatic build_deep(input int unsigned n);
    logic [1:0] opened[$];
    logic [1:0] code;
    str_q.delete();
    repeat (n) begin
      code = 2'($urandom_range(2));
      str_q.push_back(open_char(code));
      opened.push_back(code);
    end
    while (opened.size() > 0) begin
      code = opened.pop_back();
      if ($urandom_range(7) == 0) str_q.push_back(wild_char());
      else str_q.push_back(close_char(code));
    end
  endtask

  function automatic logic [7:0] noise_char();
    if ($urandom_range(1) == 1) begin
      if ($urandom_range(1) == 1) return open_char(2'($urandom_range(2)));
      return close_char(2'($urandom_range(2)));
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic add_random_strings(input int unsigned n_items);
    int unsigned start;
    int unsigned kind;
    int unsigned keep;
    start = planned;
    while (planned - start < n_items) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_nest($urandom_range(6, 1));
      end else if (kind < 67) begin
        // corrupt one character
        build_nest($urandom_range(6, 1));
        str_q[$urandom_range(str_q.size() - 1)] = noise_char();
      end else if (kind < 77) begin
        // cut the string short
        build_nest($urandom_range(6, 1));
        keep  = $urandom_range(str_q.size() - 1, 1);
        str_q = str_q[0:keep-1];
      end else if (kind < 89) begin
        str_q.delete();
        repeat ($urandom_range(8, 1)) str_q.push_back(noise_char());
      end else if (kind < 90) begin
        build_deep($urandom_range(NEST_MAX + 2, NEST_MAX - 2));
      end else begin
        // one stray character on a good nest
        build_nest($urandom_range(6, 1));
        if ($urandom_range(1) == 1) str_q.push_back(noise_char());
        else str_q.push_front(noise_char());
      end
      emit_string();
    end
  endtask

  // Drive symbol beats: hold while stalled, idle at random per phase, wait out verdicts on a drain mark
  always @(posedge clk) begin : drive
    bit        send;
    bit        hold_now;
    sym_plan_t nxt;
    send     = 1'b0;
    hold_now = 1'b0;
    if (rst) begin
      sym_valid  <= 1'b0;
      hold_pulse <= 1'b0;
    end else begin
      if (sym_valid && !sym_stall) track_symbol(sym_data);
      if (!sym_valid || !sym_stall) begin
        if (symbols_pending.size() != 0) begin
          nxt = symbols_pending[0];
          if (nxt.drain) send = (verdicts_due.size() == 0);
          else send = ($urandom_range(99) >= tx_idle_pct(nxt.mode));
        end
        if (send) begin
          void'(symbols_pending.pop_front());
          sym_data <= nxt.beat;
          cur_mode <= nxt.mode;
          hold_now = nxt.rx_hold;
        end
        sym_valid <= send;
      end
      hold_pulse <= hold_now;
    end
  end

  // Check verdict beats against the predicted queue; stall at random or for a hold period
  always @(posedge clk) begin : observe
    bbc_pkg::res_t want;
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none pending: valid_res %0d status %0d",
                 res_data.valid_res, res_data.status);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (res_data.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, res_data.valid_res);
            mismatches++;
          end
          if (res_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_data.status);
            mismatches++;
          end
        end
      end
      if (hold_pulse) hold_left = RX_HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < rx_idle_pct(cur_mode));
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("bracket_balance_checker_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    // Directed strings: brackets, wildcards, byte extremes and each error
    plan_mode = IDLE_RX_HEAVY;
    add_text("()");
    add_text("([{}])");
    add_text("(");
    add_text("((");
    add_text(")a");
    add_text("(]");
    add_text("[x");
    add_beat(8'h00, 1'b0);
    add_beat(8'hFF, 1'b1);
    add_text("(]x");
    // Stack exactly full, then one opener past full
    build_deep(NEST_MAX);
    emit_string();
    build_deep(NEST_MAX + 1);
    emit_string();
    add_random_strings(PHASE_ITEMS);

    plan_mode  = IDLE_TX_HEAVY;
    mark_drain = 1'b1;
    add_random_strings(PHASE_ITEMS);

    // Drain, then hold off the receiver while beats keep coming
    plan_mode  = IDLE_NONE;
    mark_drain = 1'b1;
    mark_hold  = 1'b1;
    add_random_strings(PHASE_ITEMS);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (symbols_pending.size() != 0 || sym_valid) @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("bracket_balance_checker_unit_tb: clean");
    end else begin
      $display("bracket_balance_checker_unit_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bbc_pkg.sv
design/bbc_ram.sv
design/bbc_core.sv
design/bracket_balance_checker_unit.sv
dv/bracket_balance_checker_unit_tb.sv
